@@ design/tccs_pkg.sv @@
// Package: shared types and constants of the text console cursor and scroll engine.
package tccs_pkg;

  typedef struct packed {
    logic        op;
    logic [7:0]  char_code;
    logic [11:0] cell_index;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [15:0] crtc_cursor_address;
    logic [15:0] read_cell;
  } result_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [2:0] REG_ATTRIBUTE = 3'd0;
  localparam logic [2:0] REG_TAB_WIDTH = 3'd1;
  localparam logic [2:0] REG_COLUMNS   = 3'd2;
  localparam logic [2:0] REG_ROWS      = 3'd3;
  localparam logic [2:0] REG_PAGE_BASE = 3'd4;

  localparam logic [7:0]  RST_ATTRIBUTE = 8'h07;
  localparam logic [7:0]  RST_TAB_WIDTH = 8'd8;
  localparam logic [7:0]  RST_COLUMNS   = 8'd80;
  localparam logic [5:0]  RST_ROWS      = 6'd25;
  localparam logic [15:0] RST_PAGE_BASE = 16'h0000;

  localparam logic [7:0] CH_LINE_FEED = 8'h0A;
  localparam logic [7:0] CH_CAR_RET   = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_BLANK     = 8'h00;

endpackage

@@ design/text_console_cursor_scroll.sv @@
// Top level: text console engine with cursor sequencer, shared multiplier and cell store.
//
//  channel   | handshake               | word
//  ----------+-------------------------+-------------------------------
//  command   | start, busy             | cmd (op, char_code, cell_index)
//  result    | done (one-cycle strobe) | result (cursor, crtc address, cell)
//  config    | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// A read passes S_RD and S_MUL before done; an ordinary character passes S_WMUL, S_WR and S_MUL.
// A tab steps an adder loop by tab_width from zero until it passes the cursor column.
// A line feed on the last row adds a copy of the store up one row and a blank fill of the last row,
// one store read and one store write a cycle.
// After reset a clearing pass over every store cell holds busy high.
// The receiver cannot stall; config writes are taken in every cycle.
module text_console_cursor_scroll #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  tccs_pkg::cmd_t       cmd,
  output logic                 done,
  output tccs_pkg::result_t    result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AW1   = $clog2(DEPTH + 1);
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ECW   = $clog2(MAX_COLS + 1);
  localparam int ERW   = $clog2(MAX_ROWS + 1);
  localparam int MW    = ECW + ERW;
  localparam int ACW   = $clog2(MAX_COLS + 256);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_WMUL  = 4'd3;
  localparam logic [3:0] S_WR    = 4'd4;
  localparam logic [3:0] S_NL    = 4'd5;
  localparam logic [3:0] S_TAB   = 4'd6;
  localparam logic [3:0] S_STOT  = 4'd7;
  localparam logic [3:0] S_SCR   = 4'd8;
  localparam logic [3:0] S_FILL  = 4'd9;
  localparam logic [3:0] S_MUL   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]       state;
  logic [7:0]       attr;
  logic [7:0]       tabw;
  logic [7:0]       ncols;
  logic [5:0]       nrows;
  logic [15:0]      page;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] line;
  logic [AW1-1:0]   prod;
  logic [AW1-1:0]   ptr;
  logic             pend;
  logic [ACW-1:0]   acc;
  logic [7:0]       ch;
  logic             cell_ok;
  logic [15:0]      rd_word;
  logic [15:0]      rdata;

  logic [15:0] store [DEPTH];

  logic [ECW-1:0]   ecols;
  logic [ERW-1:0]   erows;
  logic [7:0]       etab;
  logic [ERW-1:0]   mul_a;
  logic [MW-1:0]    mul_full;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [15:0]      mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [ECW:0]     col_inc;
  logic [ERW:0]     line_inc;
  logic             printable;

  assign ecols = (ncols == 8'd0) ? ECW'(1) :
                 (9'(ncols) > 9'(MAX_COLS)) ? ECW'(MAX_COLS) : ECW'(ncols);
  assign erows = (nrows == 6'd0) ? ERW'(1) :
                 (7'(nrows) > 7'(MAX_ROWS)) ? ERW'(MAX_ROWS) : ERW'(nrows);
  assign etab  = (tabw == 8'd0) ? 8'd1 : tabw;

  assign mul_a    = (state == S_STOT) ? erows : ERW'(line);
  assign mul_full = MW'(mul_a) * MW'(ecols);

  assign col_inc   = (ECW + 1)'(col) + (ECW + 1)'(1);
  assign line_inc  = (ERW + 1)'(line) + (ERW + 1)'(1);
  assign printable = (ch[7] == 1'b0) && (ch >= tccs_pkg::CH_SPACE);

  assign busy      = (state != S_IDLE);
  assign done      = (state == S_OUT);
  assign cfg_ready = 1'b1;

  assign result.cursor_col          = 7'(col);
  assign result.cursor_row          = 5'(line);
  assign result.crtc_cursor_address = page + 16'(prod) + 16'(col);
  assign result.read_cell           = rd_word;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(ptr);
    mem_wdata = 16'h0000;
    mem_raddr = AW'(ptr);
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_raddr = AW'(cmd.cell_index);
      end
      S_WR: begin
        mem_we    = printable;
        mem_waddr = AW'(prod + AW1'(col));
        mem_wdata = {attr, ch};
      end
      S_SCR: begin
        mem_we    = pend;
        mem_waddr = AW'(ptr - AW1'(1) - AW1'(ecols));
        mem_wdata = rdata;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = {attr, tccs_pkg::CH_BLANK};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= store[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attr  <= tccs_pkg::RST_ATTRIBUTE;
      tabw  <= tccs_pkg::RST_TAB_WIDTH;
      ncols <= tccs_pkg::RST_COLUMNS;
      nrows <= tccs_pkg::RST_ROWS;
      page  <= tccs_pkg::RST_PAGE_BASE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tccs_pkg::REG_ATTRIBUTE: attr  <= cfg_data[7:0];
        tccs_pkg::REG_TAB_WIDTH: tabw  <= cfg_data[7:0];
        tccs_pkg::REG_COLUMNS:   ncols <= cfg_data[7:0];
        tccs_pkg::REG_ROWS:      nrows <= cfg_data[5:0];
        tccs_pkg::REG_PAGE_BASE: page  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ptr   <= '0;
      pend  <= 1'b0;
      col   <= '0;
      line  <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          ptr <= ptr + AW1'(1);
          if (ptr == AW1'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            ch      <= cmd.char_code;
            rd_word <= 16'h0000;
            cell_ok <= (32'(cmd.cell_index) < 32'(DEPTH));
            state   <= (cmd.op == tccs_pkg::OP_READ) ? S_RD : S_WMUL;
          end
        end
        S_RD: begin
          rd_word <= cell_ok ? rdata : 16'h0000;
          state   <= S_MUL;
        end
        S_WMUL: begin
          prod  <= AW1'(mul_full);
          state <= S_WR;
        end
        S_WR: begin
          case (ch)
            tccs_pkg::CH_LINE_FEED: begin
              state <= S_NL;
            end
            tccs_pkg::CH_CAR_RET: begin
              col   <= '0;
              state <= S_MUL;
            end
            tccs_pkg::CH_TAB: begin
              acc   <= '0;
              state <= S_TAB;
            end
            tccs_pkg::CH_BACKSPACE: begin
              if (col != '0) begin
                col <= col - COL_W'(1);
              end
              state <= S_MUL;
            end
            default: begin
              if (col_inc >= (ECW + 1)'(ecols)) begin
                state <= S_NL;
              end else begin
                col   <= COL_W'(col_inc);
                state <= S_MUL;
              end
            end
          endcase
        end
        S_TAB: begin
          if (acc <= ACW'(col)) begin
            acc <= acc + ACW'(etab);
          end else if (acc >= ACW'(ecols)) begin
            state <= S_NL;
          end else begin
            col   <= COL_W'(acc);
            state <= S_MUL;
          end
        end
        S_NL: begin
          col <= '0;
          if (line_inc >= (ERW + 1)'(erows)) begin
            line  <= ROW_W'(erows - ERW'(1));
            state <= S_STOT;
          end else begin
            line  <= ROW_W'(line_inc);
            state <= S_MUL;
          end
        end
        S_STOT: begin
          prod  <= AW1'(mul_full);
          ptr   <= AW1'(ecols);
          pend  <= 1'b0;
          state <= S_SCR;
        end
        S_SCR: begin
          if (ptr < prod) begin
            ptr  <= ptr + AW1'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              ptr   <= prod - AW1'(ecols);
              state <= S_FILL;
            end
          end
        end
        S_FILL: begin
          ptr <= ptr + AW1'(1);
          if (ptr + AW1'(1) == prod) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= AW1'(mul_full);
          state <= S_OUT;
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
